### rtl/core/ptw_pkg.sv
// Shared types, widths and codes for the five-level page table walker.
// No dependencies; every other file in rtl/core but ptw_ram takes names from here.
package ptw_pkg;

   // Fixed payload widths
   localparam int CMD_W       = 2;
   localparam int VPN_W       = 45;
   localparam int FRAME_W     = 52;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_W     = FRAME_W + 1;   // frame number above the valid bit
   localparam int ROOT_W      = 6;
   localparam int FIRST_W     = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   // Parameter defaults
   localparam int NUM_FRAMES_DEF = 64;
   localparam int LEVELS_DEF     = 5;
   localparam int INDEX_BITS_DEF = 9;

   // Register reset values
   localparam logic [ROOT_W-1:0]  RESET_ROOT  = '0;
   localparam logic [FIRST_W-1:0] RESET_FIRST = 7'd1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFRAME = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_FRAME = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_FREE = 1'b1;

   // Frame store write source
   typedef enum logic [2:0] {
      WR_NONE,
      WR_SWEEP,
      WR_ALLOC,
      WR_MAP,
      WR_UNMAP
   } wr_sel_type;

   typedef struct packed {
      logic                load;
      logic                rd_en;
      wr_sel_type          wr_sel;
      logic                advance;
      logic                res_set;
      logic                res_from_leaf;
      logic [STATUS_W-1:0] res_status;
      logic                publish;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd_code;
      logic             root_outside;
      logic             entry_valid;
      logic             entry_outside;
      logic             free_empty;
      logic             sweep_last;
   } dp_stat_type;

endpackage

### rtl/core/ptw_req_if.sv
// Request channel of the page table walker: valid/ready plus command payload.
// Depends on ptw_pkg for field widths.
interface ptw_req_if;
   logic                         valid;
   logic                         ready;
   logic [ptw_pkg::CMD_W-1:0]    command;
   logic [ptw_pkg::VPN_W-1:0]    virtual_page;
   logic [ptw_pkg::FRAME_W-1:0]  new_frame;

   modport source (output valid, command, virtual_page, new_frame, input ready);
   modport sink   (input valid, command, virtual_page, new_frame, output ready);
endinterface

### rtl/core/ptw_rsp_if.sv
// Response channel of the page table walker: valid/ready plus result payload.
// Depends on ptw_pkg for field widths.
interface ptw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptw_pkg::FRAME_W-1:0]   frame;
   logic                          mapped;
   logic [ptw_pkg::STATUS_W-1:0]  status;

   modport source (output valid, frame, mapped, status, input ready);
   modport sink   (input valid, frame, mapped, status, output ready);
endinterface

### rtl/core/five_level_page_table_walker.sv
// Top level of the five-level page table walker.
// Depends on ptw_pkg, ptw_req_if, ptw_rsp_if, ptw_ctrl, ptw_dp (and ptw_ram below it).
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-----------------------------------
//  req_chan  | in        | valid / ready      | command, virtual_page, new_frame
//  rsp_chan  | out       | valid / ready      | frame, mapped, status
//  csr_*     | in        | csr_write_enable   | csr_index, csr_write_data
//
// One transaction at a time. Each intermediate level of a walk is a frame store
// read, then an evaluate, as the single frame store has a registered read; around
// them come accept, start check, leaf access (a write for map/unmap, a read and
// an evaluate for query) and publish.
// After reset a clearing pass zeroes all NUM_FRAMES << INDEX_BITS entries of the
// store (32768 by default), one entry per cycle; req_chan.ready stays low
// meanwhile, configuration writes are taken.
// A finished result waits in an output register; the next request transaction
// is accepted while it waits, and the walk holds before publishing until the
// output register is free.
module five_level_page_table_walker #(
   parameter int NUM_FRAMES = ptw_pkg::NUM_FRAMES_DEF,
   parameter int LEVELS     = ptw_pkg::LEVELS_DEF,
   parameter int INDEX_BITS = ptw_pkg::INDEX_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ptw_req_if.sink                         req_chan,
   ptw_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [ptw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   // command and status between sequencer and datapath
   ptw_pkg::dp_cmd_type  dp_cmd;
   ptw_pkg::dp_stat_type dp_stat;

   // sequencer: owns the handshakes and the level count
   ptw_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   // datapath: holds the request, walks the store, builds the result
   ptw_dp #(
      .NUM_FRAMES (NUM_FRAMES),
      .LEVELS     (LEVELS),
      .INDEX_BITS (INDEX_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_chan.command),
      .req_virtual_page (req_chan.virtual_page),
      .req_new_frame    (req_chan.new_frame),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .rsp_frame        (rsp_chan.frame),
      .rsp_mapped       (rsp_chan.mapped),
      .rsp_status       (rsp_chan.status)
   );

endmodule

### rtl/core/ptw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ptw_ctrl.sv
// Walk sequencer: clearing pass, level iteration, request and response handshakes.
// Depends on ptw_pkg; drives ptw_dp through dp_cmd_type.
module ptw_ctrl #(
   parameter int LEVELS = ptw_pkg::LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ptw_pkg::dp_cmd_type  cmd,
   input  ptw_pkg::dp_stat_type stat
);

   localparam int LVL_W = $clog2(LEVELS + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_READ,
      S_EVAL,
      S_LEAF,
      S_LEAF_EVAL,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_mid;
   logic             cmd_known;

   assign last_mid  = (level_ff == LVL_W'(LEVELS - 2));
   assign cmd_known = (stat.cmd_code == ptw_pkg::CMD_QUERY) ||
                      (stat.cmd_code == ptw_pkg::CMD_MAP) ||
                      (stat.cmd_code == ptw_pkg::CMD_UNMAP);

   always_comb begin
      state_in          = state_ff;
      level_in          = level_ff;
      cmd.load          = 1'b0;
      cmd.rd_en         = 1'b0;
      cmd.wr_sel        = ptw_pkg::WR_NONE;
      cmd.advance       = 1'b0;
      cmd.res_set       = 1'b0;
      cmd.res_from_leaf = 1'b0;
      cmd.res_status    = ptw_pkg::ST_OK;
      cmd.publish       = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_sel = ptw_pkg::WR_SWEEP;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               level_in = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            priority if (!cmd_known) begin
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
            end else if (stat.root_outside) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ptw_pkg::ST_OUTSIDE;
               state_in       = S_DONE;
            end else begin
               state_in = (LEVELS > 1) ? S_READ : S_LEAF;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            priority if (stat.entry_valid && stat.entry_outside) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ptw_pkg::ST_OUTSIDE;
               state_in       = S_DONE;
            end else if (stat.entry_valid) begin
               cmd.advance = 1'b1;
            end else if (stat.cmd_code != ptw_pkg::CMD_MAP) begin
               // missing path on query or unmap: quiet miss
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
            end else if (stat.free_empty) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ptw_pkg::ST_NOFRAME;
               state_in       = S_DONE;
            end else begin
               cmd.wr_sel  = ptw_pkg::WR_ALLOC;
               cmd.advance = 1'b1;
            end
            if (cmd.advance) begin
               level_in = level_ff + LVL_W'(1);
               state_in = last_mid ? S_LEAF : S_READ;
            end
         end
         S_LEAF: begin
            priority if (stat.cmd_code == ptw_pkg::CMD_QUERY) begin
               cmd.rd_en = 1'b1;
               state_in  = S_LEAF_EVAL;
            end else if (stat.cmd_code == ptw_pkg::CMD_MAP) begin
               cmd.wr_sel  = ptw_pkg::WR_MAP;
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.wr_sel  = ptw_pkg::WR_UNMAP;
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_LEAF_EVAL: begin
            cmd.res_set       = 1'b1;
            cmd.res_from_leaf = 1'b1;
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
      endcase

      priority if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/ptw_dp.sv
// Walk datapath: request registers, allocator, frame store and result registers.
// Depends on ptw_pkg and ptw_ram; commanded by ptw_ctrl.
module ptw_dp #(
   parameter int NUM_FRAMES = ptw_pkg::NUM_FRAMES_DEF,
   parameter int LEVELS     = ptw_pkg::LEVELS_DEF,
   parameter int INDEX_BITS = ptw_pkg::INDEX_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ptw_pkg::CMD_W-1:0]          req_command,
   input  logic [ptw_pkg::VPN_W-1:0]          req_virtual_page,
   input  logic [ptw_pkg::FRAME_W-1:0]        req_new_frame,
   input  logic                               csr_write_enable,
   input  logic [ptw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  ptw_pkg::dp_cmd_type                cmd,
   output ptw_pkg::dp_stat_type               stat,
   output logic [ptw_pkg::FRAME_W-1:0]        rsp_frame,
   output logic                               rsp_mapped,
   output logic [ptw_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int DEPTH    = NUM_FRAMES << INDEX_BITS;
   localparam int FIDX_W   = $clog2(NUM_FRAMES);
   localparam int ADDR_W   = FIDX_W + INDEX_BITS;
   localparam int NEED_W   = $clog2(NUM_FRAMES + 1);
   localparam int FREE_W   = (NEED_W > ptw_pkg::FIRST_W) ? NEED_W : ptw_pkg::FIRST_W;
   localparam int VP_ALIGN = ptw_pkg::VPN_W - LEVELS * INDEX_BITS;

   logic [ptw_pkg::CMD_W-1:0]     cmd_ff;
   logic [ptw_pkg::VPN_W-1:0]     vp_ff;
   logic [ptw_pkg::FRAME_W-1:0]   nf_ff;
   logic [FIDX_W-1:0]             cur_ff;
   logic [FREE_W-1:0]             next_free_ff;
   logic [ptw_pkg::ROOT_W-1:0]    root_ff;
   logic [ADDR_W-1:0]             sweep_ff;
   logic [ptw_pkg::FRAME_W-1:0]   res_frame_ff, res_frame_in;
   logic                          res_mapped_ff, res_mapped_in;
   logic [ptw_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ptw_pkg::FRAME_W-1:0]   out_frame_ff;
   logic                          out_mapped_ff;
   logic [ptw_pkg::STATUS_W-1:0]  out_status_ff;

   logic [INDEX_BITS-1:0]         idx;
   logic [ADDR_W-1:0]             walk_addr;
   logic [ptw_pkg::ENTRY_W-1:0]   rd_entry;
   logic [ptw_pkg::FRAME_W-1:0]   entry_frame;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [ptw_pkg::ENTRY_W-1:0]   wr_data;

   assign idx         = vp_ff[ptw_pkg::VPN_W-1 -: INDEX_BITS];
   assign walk_addr   = {cur_ff, idx};
   assign entry_frame = rd_entry[ptw_pkg::ENTRY_W-1:1];

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = walk_addr;
      wr_data = '0;
      unique case (cmd.wr_sel)
         ptw_pkg::WR_NONE:  wr_en = 1'b0;
         ptw_pkg::WR_SWEEP: wr_addr = sweep_ff;
         ptw_pkg::WR_ALLOC: wr_data = {ptw_pkg::FRAME_W'(next_free_ff), 1'b1};
         ptw_pkg::WR_MAP:   wr_data = {nf_ff, 1'b1};
         ptw_pkg::WR_UNMAP: wr_data = '0;
         default:           wr_en = 1'b0;
      endcase
   end

   ptw_ram #(
      .WIDTH (ptw_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (walk_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      res_frame_in  = res_frame_ff;
      res_mapped_in = res_mapped_ff;
      res_status_in = res_status_ff;
      if (cmd.res_set) begin
         if (cmd.res_from_leaf) begin
            res_frame_in  = rd_entry[0] ? entry_frame : '0;
            res_mapped_in = rd_entry[0];
            res_status_in = ptw_pkg::ST_OK;
         end else begin
            res_frame_in  = '0;
            res_mapped_in = 1'b0;
            res_status_in = cmd.res_status;
         end
      end
   end

   // control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= ptw_pkg::RESET_ROOT;
         next_free_ff <= FREE_W'(ptw_pkg::RESET_FIRST);
         sweep_ff     <= '0;
      end else begin
         if (csr_write_enable && csr_index == ptw_pkg::CSR_ROOT_FRAME) begin
            root_ff <= csr_write_data[ptw_pkg::ROOT_W-1:0];
         end
         if (csr_write_enable && csr_index == ptw_pkg::CSR_FIRST_FREE) begin
            next_free_ff <= FREE_W'(csr_write_data);
         end else if (cmd.wr_sel == ptw_pkg::WR_ALLOC) begin
            next_free_ff <= next_free_ff + FREE_W'(1);
         end
         if (cmd.wr_sel == ptw_pkg::WR_SWEEP) begin
            sweep_ff <= sweep_ff + ADDR_W'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         vp_ff  <= req_virtual_page << VP_ALIGN;
         nf_ff  <= req_new_frame;
         cur_ff <= FIDX_W'(root_ff);
      end else if (cmd.advance) begin
         vp_ff <= vp_ff << INDEX_BITS;
         if (cmd.wr_sel == ptw_pkg::WR_ALLOC) begin
            cur_ff <= next_free_ff[FIDX_W-1:0];
         end else begin
            cur_ff <= entry_frame[FIDX_W-1:0];
         end
      end
      res_frame_ff  <= res_frame_in;
      res_mapped_ff <= res_mapped_in;
      res_status_ff <= res_status_in;
      if (cmd.publish) begin
         out_frame_ff  <= res_frame_ff;
         out_mapped_ff <= res_mapped_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign stat.cmd_code      = cmd_ff;
   assign stat.root_outside  = (32'(root_ff) >= 32'(NUM_FRAMES));
   assign stat.entry_valid   = rd_entry[0];
   assign stat.entry_outside = (entry_frame >= ptw_pkg::FRAME_W'(NUM_FRAMES));
   assign stat.free_empty    = (32'(next_free_ff) >= 32'(NUM_FRAMES));
   assign stat.sweep_last    = (sweep_ff == ADDR_W'(DEPTH - 1));

   assign rsp_frame  = out_frame_ff;
   assign rsp_mapped = out_mapped_ff;
   assign rsp_status = out_status_ff;

endmodule

### rtl/core/ptw_prop_chk.sv
// Port-level properties of the page table walker, bound to the top level.
// Depends on ptw_pkg and five_level_page_table_walker.
module ptw_prop_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ptw_pkg::FRAME_W-1:0]    rsp_frame,
   input logic                           rsp_mapped,
   input logic [ptw_pkg::STATUS_W-1:0]   rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_frame) && $stable(rsp_mapped) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   a_mapped_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mapped |-> rsp_status == ptw_pkg::ST_OK)
      else $error("translation reported with error status");

   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mapped |-> rsp_frame == '0)
      else $error("frame nonzero without translation");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("handshake active right after reset");

endmodule

bind five_level_page_table_walker ptw_prop_chk u_prop_chk (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_frame  (rsp_chan.frame),
   .rsp_mapped (rsp_chan.mapped),
   .rsp_status (rsp_chan.status)
);
